### design/crontab_line_matcher_defines.svh
// Assertion macros shared by the crontab matcher
`ifndef CRONTAB_LINE_MATCHER_DEFINES_SVH
`define CRONTAB_LINE_MATCHER_DEFINES_SVH

// checked out of reset only
`define CLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/cronlm_pkg.sv
package cronlm_pkg;

  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned CFG_W      = 6;

  typedef logic [8:0] sym_t;

  localparam sym_t SYM_PERCENT = 9'd256;
  localparam sym_t SYM_NEWLINE = 9'd257;
  localparam sym_t SYM_EOF     = 9'd258;

  localparam logic [7:0] CHR_PERCENT   = 8'h25;
  localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_COMMA     = 8'h2C;
  localparam logic [7:0] CHR_DASH      = 8'h2D;
  localparam logic [7:0] CHR_STAR      = 8'h2A;
  localparam logic [7:0] CHR_SPACE     = 8'h20;
  localparam logic [7:0] CHR_TAB       = 8'h09;
  localparam logic [7:0] CHR_ZERO      = 8'h30;
  localparam logic [7:0] CHR_NINE      = 8'h39;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CMD,
    KIND_STDIN
  } kind_t;

  typedef enum logic [2:0] {
    REG_MINUTE,
    REG_HOUR,
    REG_MDAY,
    REG_MONTH,
    REG_WDAY
  } reg_idx_t;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] month;
    logic [2:0] wday;
  } now_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
    logic       done;
    logic       run;
    logic       last;
  } res_t;

  typedef struct packed {
    logic line_start;
    logic esc_pending;
  } status_t;

endpackage

### design/cronlm_parser.sv
module cronlm_parser (
  input  logic               clk,
  input  logic               rst,
  input  cronlm_pkg::now_t   now_time,
  input  logic               beat,
  input  logic [7:0]         text_byte,
  input  logic               eot,
  output cronlm_pkg::res_t   res0,
  output cronlm_pkg::res_t   res1,
  output cronlm_pkg::status_t status
);
  import cronlm_pkg::*;

  typedef enum logic [3:0] {
    PH_LINE_START,
    PH_ELEM,
    PH_LOW,
    PH_DASH,
    PH_HIGH,
    PH_GLOB,
    PH_MATCH_SKIP,
    PH_MATCH_STR,
    PH_BLANKS,
    PH_CMD_START,
    PH_COMMAND,
    PH_STDIN,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] fidx;
    logic [6:0] lo;
    logic [6:0] hi;
    logic [1:0] dc;
    logic       has_cmd;
  } pst_t;

  typedef struct packed {
    pst_t st;
    logic again;
    res_t res;
  } pass_t;

  localparam pst_t PST_RESET = '{phase: PH_LINE_START, fidx: 3'd0, lo: 7'd0, hi: 7'd0,
                                 dc: 2'd0, has_cmd: 1'b0};

  function automatic logic is_blank(sym_t s);
    return s == {1'b0, CHR_SPACE} || s == {1'b0, CHR_TAB};
  endfunction

  function automatic logic is_digit(sym_t s);
    return s >= {1'b0, CHR_ZERO} && s <= {1'b0, CHR_NINE};
  endfunction

  function automatic logic is_end(sym_t s);
    return s == SYM_NEWLINE || s == SYM_EOF;
  endfunction

  function automatic logic is_punct(sym_t s);
    return s == SYM_PERCENT || is_digit(s) || s == {1'b0, CHR_DASH} ||
           s == {1'b0, CHR_COMMA} || s == {1'b0, CHR_STAR};
  endfunction

  function automatic logic [6:0] now_val(logic [2:0] fidx, now_t n);
    logic [6:0] v;
    unique case (fidx)
      3'd0:    v = {1'b0, n.minute};
      3'd1:    v = {2'b0, n.hour};
      3'd2:    v = {2'b0, n.mday};
      3'd3:    v = {3'b0, n.month};
      3'd4:    v = {4'b0, n.wday};
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // v*10 + digit, kept to 7 bits
  function automatic logic [6:0] mac10(logic [6:0] v, sym_t s);
    return {v[3:0], 3'b0} + {v[5:0], 1'b0} + {3'b0, s[3:0]};
  endfunction

  function automatic pass_t emit(pass_t p, kind_t k, logic [7:0] b);
    pass_t r;
    r = p;
    r.res.valid = 1'b1;
    r.res.kind  = k;
    r.res.data  = b;
    r.res.done  = 1'b0;
    r.res.run   = 1'b0;
    r.res.last  = 1'b0;
    return r;
  endfunction

  function automatic pass_t finish(pass_t p, logic run, logic nl);
    pass_t r;
    r = p;
    r.res.valid = 1'b1;
    r.res.kind  = nl ? KIND_STDIN : KIND_NONE;
    r.res.data  = nl ? CHR_NEWLINE : 8'd0;
    r.res.done  = 1'b1;
    r.res.run   = run;
    r.res.last  = 1'b0;
    r.st        = PST_RESET;
    return r;
  endfunction

  function automatic pass_t matched(pass_t p, sym_t s);
    pass_t r;
    r = p;
    if (is_blank(s)) begin
      r.st.fidx  = p.st.fidx + 3'd1;
      r.st.phase = PH_BLANKS;
    end else begin
      r.st.phase = PH_MATCH_SKIP;
    end
    return r;
  endfunction

  function automatic pass_t item_end(pass_t p, sym_t s, logic [6:0] lo, logic [6:0] hi,
                                     logic [6:0] nv);
    pass_t r;
    r = p;
    if (s == {1'b0, CHR_COMMA} || is_blank(s)) begin
      if (lo <= nv && nv <= hi) begin
        r = matched(p, s);
      end else begin
        r.st.phase = is_blank(s) ? PH_SKIP : PH_ELEM;
      end
    end else begin
      r.st.phase = PH_SKIP;
      r.again    = 1'b1;
    end
    return r;
  endfunction

  function automatic pass_t do_pass(pst_t st, sym_t s, now_t n);
    pass_t      p;
    logic [6:0] nv;
    p.st    = st;
    p.again = 1'b0;
    p.res   = '0;
    nv      = now_val(st.fidx, n);
    unique case (st.phase)
      PH_LINE_START: begin
        if (!(is_blank(s) || is_end(s))) begin
          p.st.fidx  = 3'd0;
          p.st.phase = PH_ELEM;
          p.again    = 1'b1;
        end
      end
      PH_ELEM: begin
        if (is_digit(s)) begin
          p.st.lo    = {3'b0, s[3:0]};
          p.st.dc    = 2'd1;
          p.st.phase = PH_LOW;
        end else if (s == {1'b0, CHR_STAR}) begin
          p.st.phase = PH_GLOB;
        end else begin
          p.st.phase = PH_SKIP;
          p.again    = !is_blank(s);
        end
      end
      PH_LOW: begin
        if (is_digit(s)) begin
          if (st.dc < 2'd2) begin
            p.st.lo = mac10(st.lo, s);
            p.st.dc = st.dc + 2'd1;
          end else begin
            p.st.dc = 2'd3;
          end
        end else if (st.dc == 2'd3) begin
          p.st.phase = PH_SKIP;
          p.again    = 1'b1;
        end else if (s == {1'b0, CHR_DASH}) begin
          p.st.phase = PH_DASH;
        end else begin
          p = item_end(p, s, st.lo, st.lo, nv);
        end
      end
      PH_DASH: begin
        if (is_digit(s)) begin
          p.st.hi    = {3'b0, s[3:0]};
          p.st.dc    = 2'd1;
          p.st.phase = PH_HIGH;
        end else begin
          p.st.phase = PH_SKIP;
          p.again    = 1'b1;
        end
      end
      PH_HIGH: begin
        if (is_digit(s)) begin
          if (st.dc < 2'd2) begin
            p.st.hi = mac10(st.hi, s);
            p.st.dc = st.dc + 2'd1;
          end else begin
            p.st.dc = 2'd3;
          end
        end else if (st.dc == 2'd3) begin
          p.st.phase = PH_SKIP;
          p.again    = 1'b1;
        end else begin
          p = item_end(p, s, st.lo, st.hi, nv);
        end
      end
      PH_GLOB: begin
        if (s == {1'b0, CHR_COMMA} || is_blank(s)) begin
          p = matched(p, s);
        end else begin
          p.st.phase = PH_SKIP;
          p.again    = 1'b1;
        end
      end
      PH_MATCH_SKIP: begin
        if (is_blank(s)) begin
          p.st.fidx  = st.fidx + 3'd1;
          p.st.phase = PH_BLANKS;
        end else if (is_end(s)) begin
          p = finish(p, 1'b0, 1'b0);
        end else if (!is_punct(s)) begin
          p.st.phase = PH_MATCH_STR;
        end
      end
      PH_MATCH_STR: begin
        if (s == SYM_PERCENT) begin
          p.st.phase = PH_MATCH_SKIP;
        end else if (is_end(s)) begin
          p = finish(p, 1'b0, 1'b0);
        end
      end
      PH_BLANKS: begin
        if (!is_blank(s)) begin
          p.st.phase = (st.fidx >= 3'd5) ? PH_CMD_START : PH_ELEM;
          p.again    = 1'b1;
        end
      end
      PH_CMD_START: begin
        if (is_end(s)) begin
          p = finish(p, 1'b0, 1'b0);
        end else if (is_punct(s) || is_blank(s)) begin
          p.st.phase = PH_SKIP;
        end else begin
          p            = emit(p, KIND_CMD, s[7:0]);
          p.st.has_cmd = 1'b1;
          p.st.phase   = PH_COMMAND;
        end
      end
      PH_COMMAND: begin
        if (is_end(s)) begin
          p = finish(p, st.has_cmd, 1'b0);
        end else if (s == SYM_PERCENT) begin
          p.st.phase = PH_STDIN;
        end else begin
          p = emit(p, KIND_CMD, s[7:0]);
        end
      end
      PH_STDIN: begin
        if (is_end(s)) begin
          p = finish(p, st.has_cmd, 1'b1);
        end else if (s == SYM_PERCENT) begin
          p = emit(p, KIND_STDIN, CHR_NEWLINE);
        end else begin
          p = emit(p, KIND_STDIN, s[7:0]);
        end
      end
      default: begin
        if (is_end(s)) begin
          p = finish(p, 1'b0, 1'b0);
        end
      end
    endcase
    return p;
  endfunction

  // one symbol: at most four chained passes, at most one result
  function automatic pass_t feed(pst_t st, logic act, sym_t s, now_t n);
    pass_t acc;
    pass_t p;
    logic  go;
    acc.st    = st;
    acc.again = 1'b0;
    acc.res   = '0;
    go        = act;
    for (int i = 0; i < 4; i++) begin
      if (go) begin
        p      = do_pass(acc.st, s, n);
        acc.st = p.st;
        if (p.res.valid) begin
          acc.res = p.res;
        end
        go = p.again;
      end
    end
    return acc;
  endfunction

  pst_t  st;
  pst_t  st_next;
  logic  esc;
  logic  esc_next;
  logic  act_a;
  logic  act_b;
  sym_t  sym_a;
  sym_t  sym_b;
  sym_t  plain_sym;
  pass_t fa;
  pass_t fb;

  always_comb begin
    priority if (text_byte == CHR_PERCENT) begin
      plain_sym = SYM_PERCENT;
    end else if (text_byte == CHR_NEWLINE) begin
      plain_sym = SYM_NEWLINE;
    end else begin
      plain_sym = {1'b0, text_byte};
    end

    act_a = 1'b0;
    sym_a = {1'b0, CHR_BACKSLASH};
    act_b = 1'b0;
    sym_b = plain_sym;
    if (eot) begin
      act_a = esc;
      act_b = 1'b1;
      sym_b = SYM_EOF;
    end else if (esc && text_byte == CHR_PERCENT) begin
      act_a = 1'b1;
      sym_a = {1'b0, CHR_PERCENT};
    end else if (esc && text_byte == CHR_NEWLINE) begin
      act_a = 1'b0;
    end else begin
      act_a = esc;
      act_b = text_byte != CHR_BACKSLASH;
    end
    esc_next = !eot && text_byte == CHR_BACKSLASH;

    fa      = feed(st, act_a, sym_a, now_time);
    fb      = feed(fa.st, act_b, sym_b, now_time);
    st_next = fb.st;

    if (fa.res.valid) begin
      res0 = fa.res;
      res1 = fb.res;
    end else begin
      res0 = fb.res;
      res1 = '0;
    end
    if (res1.valid) begin
      res1.last = 1'b1;
    end else begin
      res0.last = res0.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= PST_RESET;
      esc <= 1'b0;
    end else if (beat) begin
      st  <= st_next;
      esc <= esc_next;
    end
  end

  assign status.line_start  = st.phase == PH_LINE_START;
  assign status.esc_pending = esc;

endmodule

### design/cronlm_outq.sv
module cronlm_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cronlm_pkg::res_t in0,
  input  cronlm_pkg::res_t in1,
  output logic             has_room,
  output logic             head_valid,
  output cronlm_pkg::res_t head,
  input  logic             head_take
);
  import cronlm_pkg::*;

  localparam int unsigned PW = $clog2(OUTQ_DEPTH);
  localparam int unsigned CW = $clog2(OUTQ_DEPTH + 1);

  res_t          q [OUTQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] n_push;
  logic          pop;

  assign pop        = head_valid && head_take;
  assign n_push     = push ? (CW'(in0.valid) + CW'(in1.valid)) : '0;
  assign count_next = count + n_push - CW'(pop);
  assign head_valid = count != '0;
  assign head       = q[rd_ptr];
  assign has_room   = count <= CW'(OUTQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push && in0.valid) begin
      q[wr_ptr] <= in0;
    end
    if (push && in1.valid) begin
      q[wr_ptr + PW'(1)] <= in1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[PW-1:0];
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

endmodule

### design/crontab_line_matcher.sv
// Crontab line matcher.
// Slave stream: one crontab text byte per beat in s_tdata; s_tlast marks end of
// table (the byte is then ignored). Master stream: one result per beat; m_tuser
// is the byte kind (none, command, stdin), m_tdata carries the unescaped byte,
// the line-done flag and the run flag, and m_tlast flags the final result that
// one input beat caused. An input beat yields zero, one or two results.
// Config: write cfg_data into cfg_index 0..4 (minute, hour, day of month, month,
// weekday) with cfg_we, only while no results are outstanding.
// Latency: with the queue empty, a result is presented the cycle after its input
// beat is taken.
// Throughput: one input beat per cycle while s_tready is high; a beat giving two
// results presents them one after the other. The parser decides each beat
// combinationally; results go through a four-entry output queue; s_tready stays
// high while it has room for two more, so input flows while the head result waits.
// When m_tready is low the queue fills; s_tready drops once three results wait
// and rises again when no more than two remain.
// Reset clears the parser to line start, empties the queue and restores the
// time registers to 0:00, day 1, month 1, Sunday.
`include "crontab_line_matcher_defines.svh"

module crontab_line_matcher (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [15:0] m_tdata,  // [7:0] out_byte, [8] line_done, [9] run_command
  output logic [1:0] m_tuser,   // [1:0] byte_kind
  output logic       m_tlast,   // last_of_run
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [cronlm_pkg::CFG_W-1:0] cfg_data
);
  import cronlm_pkg::*;

  now_t    now_time;
  logic    beat;
  logic    has_room;
  logic    eot_beat;
  logic    parser_idle;
  res_t    res0;
  res_t    res1;
  res_t    head;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_time <= '{minute: 6'd0, hour: 5'd0, mday: 5'd1, month: 4'd1, wday: 3'd0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MINUTE: now_time.minute <= cfg_data[5:0];
        REG_HOUR:   now_time.hour   <= cfg_data[4:0];
        REG_MDAY:   now_time.mday   <= cfg_data[4:0];
        REG_MONTH:  now_time.month  <= cfg_data[3:0];
        REG_WDAY:   now_time.wday   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign s_tready = has_room;
  assign beat     = s_tvalid && s_tready;

  cronlm_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .now_time  (now_time),
    .beat      (beat),
    .text_byte (s_tdata),
    .eot       (s_tlast),
    .res0      (res0),
    .res1      (res1),
    .status    (status)
  );

  cronlm_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (beat),
    .in0        (res0),
    .in1        (res1),
    .has_room   (has_room),
    .head_valid (m_tvalid),
    .head       (head),
    .head_take  (m_tready)
  );

  assign m_tdata = {6'b0, head.run, head.done, head.data};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  assign eot_beat    = beat && s_tlast;
  assign parser_idle = status.line_start && !status.esc_pending;

  `CLM_ASSERT(a_run_with_done, m_tvalid && head.run |-> head.done, "run flag without line end")
  `CLM_ASSERT(a_cmd_not_done, m_tvalid && head.kind == KIND_CMD |-> !head.done, "cmd byte ends line")
  `CLM_ASSERT(a_eot_line_start, eot_beat |=> parser_idle, "end of table left parser mid line")
  `CLM_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "results pending after reset")

endmodule
